>>> hdl/ahl_pkg.sv
// ----------------------------------------------------------------------------
// ahl_pkg
// shared types and codes of the allocation ledger hash table
// ----------------------------------------------------------------------------
package ahl_pkg;

    localparam logic [31:0] GOLDEN = 32'd2654435761;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;

    localparam logic [2:0] ST_RECORDED = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_NULL     = 3'd2;
    localparam logic [2:0] ST_FREED    = 3'd3;
    localparam logic [2:0] ST_UNKNOWN  = 3'd4;
    localparam logic [2:0] ST_READ     = 3'd5;
    localparam logic [2:0] ST_UNUSED   = 3'd6;

    typedef struct packed {
        logic [31:0] pc;
        logic [31:0] live;
        logic [31:0] lifetime;
        logic [31:0] peak;
        logic [31:0] blocks;
        logic [31:0] calls;
    } site_rec_t;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_CLR,
        CMD_LATCH,
        CMD_NULL,
        CMD_RD_EMPTY,
        CMD_SITE_RD_SEL,
        CMD_RD_RES,
        CMD_HASH_A,
        CMD_SET_H,
        CMD_SLOT_RD_H,
        CMD_PROBE_NEXT,
        CMD_MISS,
        CMD_UNKNOWN,
        CMD_SRCH_INIT,
        CMD_SITE_RD_I,
        CMD_SRCH_NEXT,
        CMD_SITE_FOUND,
        CMD_SITE_NOMATCH,
        CMD_SITE_RD_S,
        CMD_ALLOC_UPD,
        CMD_FREE_SITE,
        CMD_FREE_UPD,
        CMD_RJ_RD,
        CMD_RJ_TAKE,
        CMD_SET_K,
        CMD_RK_RD,
        CMD_RK_NEXT,
        CMD_RK_PUT,
        CMD_PUB
    } cmd_t;

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_DEC,
        S_RRES,
        S_HASH,
        S_PRD,
        S_PCHK,
        S_SRD,
        S_SCHK,
        S_SRDS,
        S_AUPD,
        S_FUPD,
        S_RJRD,
        S_RJCHK,
        S_RHASH,
        S_RKRD,
        S_RKCHK,
        S_OUT
    } state_t;

    typedef struct packed {
        logic in_valid;
        logic clr_last;
        logic op_alloc;
        logic op_free;
        logic a_zero;
        logic sel_ok;
        logic hash_done;
        logic slot_zero;
        logic slot_hit;
        logic tries_over;
        logic srch_more;
        logic site_match;
        logic out_free;
    } dp_status_t;

endpackage

>>> hdl/ahl_ifs.sv
// ----------------------------------------------------------------------------
// ahl request and response channels
// valid/ready channels carrying one event item and one result item
// ----------------------------------------------------------------------------
interface ahl_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] address;
    logic [31:0] block_size;
    logic [31:0] caller_pc;
    logic [8:0]  site_select;

    modport source (output valid, opcode, address, block_size, caller_pc, site_select,
                    input ready);
    modport sink (input valid, opcode, address, block_size, caller_pc, site_select,
                  output ready);
endinterface

interface ahl_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] freed_size;
    logic [8:0]  site_index;
    logic [31:0] site_pc;
    logic [31:0] site_live_bytes;
    logic [31:0] site_lifetime_bytes;
    logic [31:0] site_peak_bytes;
    logic [31:0] site_live_count;
    logic [31:0] site_call_count;
    logic [31:0] global_live_bytes;
    logic [31:0] global_peak_bytes;
    logic [31:0] missed_count;

    modport source (output valid, status, freed_size, site_index, site_pc, site_live_bytes,
                    site_lifetime_bytes, site_peak_bytes, site_live_count,
                    site_call_count, global_live_bytes, global_peak_bytes, missed_count,
                    input ready);
    modport sink (input valid, status, freed_size, site_index, site_pc, site_live_bytes,
                  site_lifetime_bytes, site_peak_bytes, site_live_count,
                  site_call_count, global_live_bytes, global_peak_bytes, missed_count,
                  output ready);
endinterface

>>> hdl/allocation_ledger_hash_table.sv
// ----------------------------------------------------------------------------
// allocation_ledger_hash_table
// live-block ledger with linear-probed slot table and call-site records
// ----------------------------------------------------------------------------
// one item at a time; each item waits in the output state while the response is stalled
// alloc/free probe the slot table linearly from the home slot; alloc then compares the
// site records against the caller pc until it finds the match
// free then rehashes each entry of the following run and moves it to the first free
// slot found by probing from its home slot
// reset: clearing pass over the slot memory, no item taken meanwhile
module allocation_ledger_hash_table #(
    parameter int SLOTS       = 16384,
    parameter int SITES       = 512,
    parameter int PROBE_LIMIT = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    ahl_req_if.sink   req,
    ahl_rsp_if.source rsp
);
    ahl_pkg::cmd_t       cmd;
    ahl_pkg::dp_status_t st;
    logic                in_ready;

    ahl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .st       (st),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    ahl_datapath #(
        .SLOTS       (SLOTS),
        .SITES       (SITES),
        .PROBE_LIMIT (PROBE_LIMIT)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .cmd      (cmd),
        .in_ready (in_ready),
        .st       (st)
    );
endmodule

>>> hdl/ahl_hash.sv
// ----------------------------------------------------------------------------
// ahl_hash
// multiplicative address hash reduced modulo the slot count, registered and ready in the
// cycle after start
// ----------------------------------------------------------------------------
module ahl_hash #(
    parameter int SLOTS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [31:0]              value,
    output logic                     done,
    output logic [$clog2(SLOTS)-1:0] hash
);
    localparam int SW = $clog2(SLOTS);

    logic [31:0] prod_reg;
    logic        done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= 32'((value >> 4) * ahl_pkg::GOLDEN);
        end
    end

    // slot count is a power of two, so the modulo keeps the low bits
    assign done = done_reg;
    assign hash = prod_reg[SW-1:0];
endmodule

>>> hdl/ahl_datapath.sv
// ----------------------------------------------------------------------------
// ahl_datapath
// slot and site memories, counters, probe pointers and the result register
// ----------------------------------------------------------------------------
module ahl_datapath #(
    parameter int SLOTS,
    parameter int SITES,
    parameter int PROBE_LIMIT
) (
    input  logic                clk,
    input  logic                rst_n,
    ahl_req_if.sink             req,
    ahl_rsp_if.source           rsp,
    input  ahl_pkg::cmd_t       cmd,
    input  logic                in_ready,
    output ahl_pkg::dp_status_t st
);
    localparam int SW  = $clog2(SLOTS);
    localparam int SIW = $clog2(SITES);
    localparam int TW  = $clog2(PROBE_LIMIT + 1);
    localparam int SEW = 64 + SIW;

    // latched item
    logic [1:0]  op_reg;
    logic [31:0] a_reg;
    logic [31:0] n_reg;
    logic [31:0] pc_reg;
    logic [8:0]  sel_reg;

    logic [SW-1:0]  h_reg;
    logic [SW-1:0]  j_reg;
    logic [SW-1:0]  k_reg;
    logic [SW-1:0]  clr_reg;
    logic [TW-1:0]  tries_reg;
    logic [SIW:0]   i_reg;
    logic [SIW-1:0] s_reg;
    logic           new_reg;
    logic [SIW:0]   used_reg;
    logic [31:0]    total_live_reg;
    logic [31:0]    total_peak_reg;
    logic [31:0]    missed_reg;
    logic [SEW-1:0] t_reg;

    logic [2:0]         res_status_reg;
    logic [31:0]        res_freed_reg;
    logic [8:0]         res_index_reg;
    ahl_pkg::site_rec_t res_rec_reg;

    logic               out_valid_reg;
    logic [2:0]         out_status_reg;
    logic [31:0]        out_freed_reg;
    logic [8:0]         out_index_reg;
    ahl_pkg::site_rec_t out_rec_reg;
    logic [31:0]        out_live_reg;
    logic [31:0]        out_peak_reg;
    logic [31:0]        out_missed_reg;

    // memories
    logic [SEW-1:0]     slot_mem [SLOTS];
    logic [SEW-1:0]     slot_rd_reg;
    ahl_pkg::site_rec_t site_mem [SITES];
    ahl_pkg::site_rec_t site_rd_reg;

    logic               slot_we;
    logic [SW-1:0]      slot_wa;
    logic [SEW-1:0]     slot_wd;
    logic               slot_re;
    logic [SW-1:0]      slot_ra;
    logic               site_we;
    ahl_pkg::site_rec_t site_wd;
    logic               site_re;
    logic [SIW-1:0]     site_ra;

    logic [31:0]        slot_addr;
    logic [31:0]        slot_size;
    logic [SIW-1:0]     slot_site;

    logic               hash_start;
    logic [31:0]        hash_value;
    logic               hash_done;
    logic [SW-1:0]      hash;

    ahl_pkg::site_rec_t base_rec;
    ahl_pkg::site_rec_t alloc_rec;
    ahl_pkg::site_rec_t free_rec;
    logic [31:0]        total_add;

    function automatic logic [SW-1:0] nxt(input logic [SW-1:0] x);
        return (x == SW'(SLOTS - 1)) ? '0 : x + SW'(1);
    endfunction

    assign slot_addr = slot_rd_reg[SEW-1 -: 32];
    assign slot_size = slot_rd_reg[SIW +: 32];
    assign slot_site = slot_rd_reg[SIW-1:0];

    ahl_hash #(.SLOTS(SLOTS)) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .value (hash_value),
        .done  (hash_done),
        .hash  (hash)
    );

    assign hash_start = (cmd == ahl_pkg::CMD_HASH_A) || (cmd == ahl_pkg::CMD_RJ_TAKE);
    assign hash_value = (cmd == ahl_pkg::CMD_HASH_A) ? a_reg : slot_addr;

    // new site records start from zero counters
    always_comb
    begin
        base_rec = site_rd_reg;
        if (new_reg)
        begin
            base_rec    = '0;
            base_rec.pc = pc_reg;
        end
        alloc_rec          = base_rec;
        alloc_rec.live     = base_rec.live + n_reg;
        alloc_rec.lifetime = base_rec.lifetime + n_reg;
        alloc_rec.blocks   = base_rec.blocks + 32'd1;
        alloc_rec.calls    = base_rec.calls + 32'd1;
        if (alloc_rec.live > base_rec.peak)
        begin
            alloc_rec.peak = alloc_rec.live;
        end
        free_rec        = site_rd_reg;
        free_rec.live   = site_rd_reg.live - n_reg;
        free_rec.blocks = site_rd_reg.blocks - 32'd1;
    end

    assign total_add = total_live_reg + n_reg;

    always_comb
    begin
        slot_we = 1'b0;
        slot_wa = h_reg;
        slot_wd = '0;
        slot_re = 1'b0;
        slot_ra = h_reg;
        site_we = 1'b0;
        site_wd = alloc_rec;
        site_re = 1'b0;
        site_ra = s_reg;
        case (cmd)
            ahl_pkg::CMD_CLR:
            begin
                slot_we = 1'b1;
                slot_wa = clr_reg;
            end
            ahl_pkg::CMD_ALLOC_UPD:
            begin
                slot_we = 1'b1;
                slot_wd = {a_reg, n_reg, s_reg};
                site_we = 1'b1;
            end
            ahl_pkg::CMD_FREE_UPD:
            begin
                slot_we = 1'b1;
                site_we = 1'b1;
                site_wd = free_rec;
            end
            ahl_pkg::CMD_RJ_TAKE:
            begin
                slot_we = 1'b1;
                slot_wa = j_reg;
            end
            ahl_pkg::CMD_RK_PUT:
            begin
                slot_we = 1'b1;
                slot_wa = k_reg;
                slot_wd = t_reg;
            end
            ahl_pkg::CMD_SLOT_RD_H:
            begin
                slot_re = 1'b1;
            end
            ahl_pkg::CMD_RJ_RD:
            begin
                slot_re = 1'b1;
                slot_ra = nxt(h_reg);
            end
            ahl_pkg::CMD_RK_RD:
            begin
                slot_re = 1'b1;
                slot_ra = k_reg;
            end
            ahl_pkg::CMD_SITE_RD_SEL:
            begin
                site_re = 1'b1;
                site_ra = SIW'(sel_reg);
            end
            ahl_pkg::CMD_SITE_RD_I:
            begin
                site_re = 1'b1;
                site_ra = i_reg[SIW-1:0];
            end
            ahl_pkg::CMD_SITE_RD_S:
            begin
                site_re = 1'b1;
            end
            ahl_pkg::CMD_FREE_SITE:
            begin
                site_re = 1'b1;
                site_ra = slot_site;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_wa] <= slot_wd;
        end
        if (slot_re)
        begin
            slot_rd_reg <= slot_mem[slot_ra];
        end
        if (site_we)
        begin
            site_mem[s_reg] <= site_wd;
        end
        if (site_re)
        begin
            site_rd_reg <= site_mem[site_ra];
        end
    end

    // control state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg        <= '0;
            used_reg       <= '0;
            total_live_reg <= '0;
            total_peak_reg <= '0;
            missed_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd == ahl_pkg::CMD_PUB)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd)
                ahl_pkg::CMD_CLR:
                begin
                    clr_reg <= clr_reg + SW'(1);
                end
                ahl_pkg::CMD_MISS:
                begin
                    missed_reg <= missed_reg + 32'd1;
                end
                ahl_pkg::CMD_SITE_NOMATCH:
                begin
                    if (used_reg != (SIW+1)'(SITES))
                    begin
                        used_reg <= used_reg + (SIW+1)'(1);
                    end
                end
                ahl_pkg::CMD_ALLOC_UPD:
                begin
                    total_live_reg <= total_add;
                    if (total_add > total_peak_reg)
                    begin
                        total_peak_reg <= total_add;
                    end
                end
                ahl_pkg::CMD_FREE_UPD:
                begin
                    total_live_reg <= total_live_reg - n_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    // working registers and result payload
    always_ff @(posedge clk)
    begin
        case (cmd)
            ahl_pkg::CMD_LATCH:
            begin
                op_reg  <= req.opcode;
                a_reg   <= req.address;
                n_reg   <= req.block_size;
                pc_reg  <= req.caller_pc;
                sel_reg <= req.site_select;
            end
            ahl_pkg::CMD_NULL, ahl_pkg::CMD_MISS, ahl_pkg::CMD_UNKNOWN:
            begin
                res_status_reg <= (cmd == ahl_pkg::CMD_NULL) ? ahl_pkg::ST_NULL :
                                  (cmd == ahl_pkg::CMD_MISS) ? ahl_pkg::ST_FULL :
                                  ahl_pkg::ST_UNKNOWN;
                res_freed_reg  <= '0;
                res_index_reg  <= '0;
                res_rec_reg    <= '0;
            end
            ahl_pkg::CMD_RD_EMPTY:
            begin
                res_status_reg <= ahl_pkg::ST_UNUSED;
                res_freed_reg  <= '0;
                res_index_reg  <= sel_reg;
                res_rec_reg    <= '0;
            end
            ahl_pkg::CMD_RD_RES:
            begin
                res_status_reg <= ahl_pkg::ST_READ;
                res_freed_reg  <= '0;
                res_index_reg  <= sel_reg;
                res_rec_reg    <= site_rd_reg;
            end
            ahl_pkg::CMD_SET_H:
            begin
                h_reg     <= hash;
                tries_reg <= '0;
            end
            ahl_pkg::CMD_PROBE_NEXT:
            begin
                h_reg     <= nxt(h_reg);
                tries_reg <= tries_reg + TW'(1);
            end
            ahl_pkg::CMD_SRCH_INIT:
            begin
                i_reg <= '0;
            end
            ahl_pkg::CMD_SRCH_NEXT:
            begin
                i_reg <= i_reg + (SIW+1)'(1);
            end
            ahl_pkg::CMD_SITE_FOUND:
            begin
                s_reg   <= i_reg[SIW-1:0];
                new_reg <= 1'b0;
            end
            ahl_pkg::CMD_SITE_NOMATCH:
            begin
                if (used_reg == (SIW+1)'(SITES))
                begin
                    s_reg   <= SIW'(SITES - 1);
                    new_reg <= 1'b0;
                end
                else
                begin
                    s_reg   <= used_reg[SIW-1:0];
                    new_reg <= 1'b1;
                end
            end
            ahl_pkg::CMD_ALLOC_UPD:
            begin
                res_status_reg <= ahl_pkg::ST_RECORDED;
                res_freed_reg  <= '0;
                res_index_reg  <= 9'(s_reg);
                res_rec_reg    <= alloc_rec;
            end
            ahl_pkg::CMD_FREE_SITE:
            begin
                n_reg   <= slot_size;
                s_reg   <= slot_site;
                new_reg <= 1'b0;
            end
            ahl_pkg::CMD_FREE_UPD:
            begin
                res_status_reg <= ahl_pkg::ST_FREED;
                res_freed_reg  <= n_reg;
                res_index_reg  <= 9'(s_reg);
                res_rec_reg    <= free_rec;
            end
            ahl_pkg::CMD_RJ_RD:
            begin
                j_reg <= nxt(h_reg);
            end
            ahl_pkg::CMD_RJ_TAKE:
            begin
                t_reg <= slot_rd_reg;
            end
            ahl_pkg::CMD_SET_K:
            begin
                k_reg <= hash;
            end
            ahl_pkg::CMD_RK_NEXT:
            begin
                k_reg <= nxt(k_reg);
            end
            ahl_pkg::CMD_RK_PUT:
            begin
                h_reg <= j_reg;
            end
            ahl_pkg::CMD_PUB:
            begin
                out_status_reg <= res_status_reg;
                out_freed_reg  <= res_freed_reg;
                out_index_reg  <= res_index_reg;
                out_rec_reg    <= res_rec_reg;
                out_live_reg   <= total_live_reg;
                out_peak_reg   <= total_peak_reg;
                out_missed_reg <= missed_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        st.in_valid   = req.valid;
        st.clr_last   = (clr_reg == SW'(SLOTS - 1));
        st.op_alloc   = (op_reg == ahl_pkg::OP_ALLOC);
        st.op_free    = (op_reg == ahl_pkg::OP_FREE);
        st.a_zero     = (a_reg == 32'd0);
        st.sel_ok     = (32'(sel_reg) < 32'(used_reg));
        st.hash_done  = hash_done;
        st.slot_zero  = (slot_addr == 32'd0);
        st.slot_hit   = (slot_addr == a_reg);
        st.tries_over = (tries_reg >= TW'(PROBE_LIMIT));
        st.srch_more  = (i_reg < used_reg);
        st.site_match = (site_rd_reg.pc == pc_reg);
        st.out_free   = !out_valid_reg || rsp.ready;
    end

    assign req.ready               = in_ready;
    assign rsp.valid               = out_valid_reg;
    assign rsp.status              = out_status_reg;
    assign rsp.freed_size          = out_freed_reg;
    assign rsp.site_index          = out_index_reg;
    assign rsp.site_pc             = out_rec_reg.pc;
    assign rsp.site_live_bytes     = out_rec_reg.live;
    assign rsp.site_lifetime_bytes = out_rec_reg.lifetime;
    assign rsp.site_peak_bytes     = out_rec_reg.peak;
    assign rsp.site_live_count     = out_rec_reg.blocks;
    assign rsp.site_call_count     = out_rec_reg.calls;
    assign rsp.global_live_bytes   = out_live_reg;
    assign rsp.global_peak_bytes   = out_peak_reg;
    assign rsp.missed_count        = out_missed_reg;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(used_reg) <= SITES)
        else $error("site fill count beyond table");
    a_tries_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == ahl_pkg::CMD_PROBE_NEXT |-> 32'(tries_reg) < PROBE_LIMIT)
        else $error("probe count beyond limit");
    a_peak_after_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == ahl_pkg::CMD_ALLOC_UPD |=> total_peak_reg >= total_live_reg)
        else $error("global peak below live bytes after allocation");
    a_pub_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == ahl_pkg::CMD_PUB |=> out_valid_reg)
        else $error("published item not shown");
`endif
endmodule

>>> hdl/ahl_ctrl.sv
// ----------------------------------------------------------------------------
// ahl_ctrl
// sequencer for clear, probe, site search, update and run reinsertion
// ----------------------------------------------------------------------------
module ahl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  ahl_pkg::dp_status_t st,
    output ahl_pkg::cmd_t       cmd,
    output logic                in_ready
);
    ahl_pkg::state_t state_reg;
    ahl_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ahl_pkg::S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = ahl_pkg::CMD_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            ahl_pkg::S_CLR:
            begin
                cmd = ahl_pkg::CMD_CLR;
                if (st.clr_last)
                begin
                    state_next = ahl_pkg::S_IDLE;
                end
            end
            ahl_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (st.in_valid)
                begin
                    cmd        = ahl_pkg::CMD_LATCH;
                    state_next = ahl_pkg::S_DEC;
                end
            end
            ahl_pkg::S_DEC:
            begin
                if (!st.op_alloc && !st.op_free)
                begin
                    if (st.sel_ok)
                    begin
                        cmd        = ahl_pkg::CMD_SITE_RD_SEL;
                        state_next = ahl_pkg::S_RRES;
                    end
                    else
                    begin
                        cmd        = ahl_pkg::CMD_RD_EMPTY;
                        state_next = ahl_pkg::S_OUT;
                    end
                end
                else if (st.a_zero)
                begin
                    cmd        = ahl_pkg::CMD_NULL;
                    state_next = ahl_pkg::S_OUT;
                end
                else
                begin
                    cmd        = ahl_pkg::CMD_HASH_A;
                    state_next = ahl_pkg::S_HASH;
                end
            end
            ahl_pkg::S_RRES:
            begin
                cmd        = ahl_pkg::CMD_RD_RES;
                state_next = ahl_pkg::S_OUT;
            end
            ahl_pkg::S_HASH:
            begin
                if (st.hash_done)
                begin
                    cmd        = ahl_pkg::CMD_SET_H;
                    state_next = ahl_pkg::S_PRD;
                end
            end
            ahl_pkg::S_PRD:
            begin
                cmd        = ahl_pkg::CMD_SLOT_RD_H;
                state_next = ahl_pkg::S_PCHK;
            end
            ahl_pkg::S_PCHK:
            begin
                if (st.op_alloc)
                begin
                    if (st.slot_zero)
                    begin
                        cmd        = ahl_pkg::CMD_SRCH_INIT;
                        state_next = ahl_pkg::S_SRD;
                    end
                    else if (st.tries_over)
                    begin
                        cmd        = ahl_pkg::CMD_MISS;
                        state_next = ahl_pkg::S_OUT;
                    end
                    else
                    begin
                        cmd        = ahl_pkg::CMD_PROBE_NEXT;
                        state_next = ahl_pkg::S_PRD;
                    end
                end
                else
                begin
                    if (st.slot_hit)
                    begin
                        cmd        = ahl_pkg::CMD_FREE_SITE;
                        state_next = ahl_pkg::S_FUPD;
                    end
                    else if (st.slot_zero || st.tries_over)
                    begin
                        cmd        = ahl_pkg::CMD_UNKNOWN;
                        state_next = ahl_pkg::S_OUT;
                    end
                    else
                    begin
                        cmd        = ahl_pkg::CMD_PROBE_NEXT;
                        state_next = ahl_pkg::S_PRD;
                    end
                end
            end
            ahl_pkg::S_SRD:
            begin
                if (st.srch_more)
                begin
                    cmd        = ahl_pkg::CMD_SITE_RD_I;
                    state_next = ahl_pkg::S_SCHK;
                end
                else
                begin
                    cmd        = ahl_pkg::CMD_SITE_NOMATCH;
                    state_next = ahl_pkg::S_SRDS;
                end
            end
            ahl_pkg::S_SCHK:
            begin
                // record already in the read register on a match
                if (st.site_match)
                begin
                    cmd        = ahl_pkg::CMD_SITE_FOUND;
                    state_next = ahl_pkg::S_AUPD;
                end
                else
                begin
                    cmd        = ahl_pkg::CMD_SRCH_NEXT;
                    state_next = ahl_pkg::S_SRD;
                end
            end
            ahl_pkg::S_SRDS:
            begin
                cmd        = ahl_pkg::CMD_SITE_RD_S;
                state_next = ahl_pkg::S_AUPD;
            end
            ahl_pkg::S_AUPD:
            begin
                cmd        = ahl_pkg::CMD_ALLOC_UPD;
                state_next = ahl_pkg::S_OUT;
            end
            ahl_pkg::S_FUPD:
            begin
                cmd        = ahl_pkg::CMD_FREE_UPD;
                state_next = ahl_pkg::S_RJRD;
            end
            ahl_pkg::S_RJRD:
            begin
                cmd        = ahl_pkg::CMD_RJ_RD;
                state_next = ahl_pkg::S_RJCHK;
            end
            ahl_pkg::S_RJCHK:
            begin
                if (st.slot_zero)
                begin
                    state_next = ahl_pkg::S_OUT;
                end
                else
                begin
                    cmd        = ahl_pkg::CMD_RJ_TAKE;
                    state_next = ahl_pkg::S_RHASH;
                end
            end
            ahl_pkg::S_RHASH:
            begin
                if (st.hash_done)
                begin
                    cmd        = ahl_pkg::CMD_SET_K;
                    state_next = ahl_pkg::S_RKRD;
                end
            end
            ahl_pkg::S_RKRD:
            begin
                cmd        = ahl_pkg::CMD_RK_RD;
                state_next = ahl_pkg::S_RKCHK;
            end
            ahl_pkg::S_RKCHK:
            begin
                if (st.slot_zero)
                begin
                    cmd        = ahl_pkg::CMD_RK_PUT;
                    state_next = ahl_pkg::S_RJRD;
                end
                else
                begin
                    cmd        = ahl_pkg::CMD_RK_NEXT;
                    state_next = ahl_pkg::S_RKRD;
                end
            end
            ahl_pkg::S_OUT:
            begin
                if (st.out_free)
                begin
                    cmd        = ahl_pkg::CMD_PUB;
                    state_next = ahl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ahl_pkg::S_IDLE;
            end
        endcase
    end
endmodule
